[rtl/gffmc_pkg.sv]
// Shared types and constants for the grid flood-fill match-and-clear block.
package gffmc_pkg;

  localparam int GRID_ROWS_DEF   = 5;
  localparam int GRID_COLS_DEF   = 5;
  localparam int STACK_DEPTH_DEF = 128;

  localparam int COLOUR_W = 3;
  localparam int COORD_W  = 4;              // stack entry holds {row[3:0], col[3:0]}
  localparam int ENTRY_W  = 2 * COORD_W;
  localparam int COUNT_W  = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd31;
  localparam logic [COUNT_W-1:0] THR_RESET  = 5'd3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SELECT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TARGET,
    S_POP,
    S_POPWAIT,
    S_NREAD,
    S_NCHK,
    S_SWEEP,
    S_DONE
  } state_e;

endpackage

[rtl/gffmc_board_mem.sv]
// Board colour memory: one write port, one registered read port.
module gffmc_board_mem
  import gffmc_pkg::*;
#(
  parameter int CELLS  = GRID_ROWS_DEF * GRID_COLS_DEF,
  parameter int CELL_W = $clog2(CELLS)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [CELL_W-1:0]   waddr_i,
  input  logic [COLOUR_W-1:0] wdata_i,
  input  logic [CELL_W-1:0]   raddr_i,
  output logic [COLOUR_W-1:0] rdata_o
);

  logic [COLOUR_W-1:0] mem_q [CELLS];
  logic [COLOUR_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/gffmc_stack_mem.sv]
// Work stack memory for the flood fill: one write port, one registered read port.
module gffmc_stack_mem
  import gffmc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int SA_W        = $clog2(STACK_DEPTH)
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [SA_W-1:0]    waddr_i,
  input  logic [ENTRY_W-1:0] wdata_i,
  input  logic [SA_W-1:0]    raddr_i,
  output logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [STACK_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/grid_flood_fill_match_clear.sv]
// Top level: sequencer, neighbor probe unit and result register of the flood-fill block.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries opcode, row, column, colour.
//   A write stores one cell colour; a select flood-fills the 4-connected region of
//   the selected cell's colour, counts it and empties it when the count reaches
//   match_threshold. Each transaction yields one result on the output channel
//   (out_valid_o / out_stall_i): match_count and cleared (both 0 for writes and for
//   coordinates outside the grid).
//   A write or out-of-range item shows its result in the cycle after it is accepted.
//   A select fetches the target colour (S_TARGET), then for each counted cell pops an
//   entry (S_POP, S_POPWAIT), probes each direction (S_NREAD) and checks each neighbor
//   that is in the grid and not yet visited (S_NCHK); S_POP then finds the stack empty,
//   a clearing select sweeps all GRID_ROWS*GRID_COLS cells, and S_DONE posts the result.
//   The single board read port and single stack read port set this order of steps.
//   One item is processed at a time; in_stall_o is high while a select runs and
//   while an undelivered result is stalled.
//   If the receiver stalls, the result register holds its value until taken.
//   Reset empties the stack and visited map, sets match_threshold to 3 and leaves
//   the board undefined until cells are written.
module grid_flood_fill_match_clear
  import gffmc_pkg::*;
#(
  parameter int GRID_ROWS   = GRID_ROWS_DEF,
  parameter int GRID_COLS   = GRID_COLS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         column_i,
  input  logic [2:0]         colour_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COUNT_W-1:0] match_count_o,
  output logic               cleared_o
);

  localparam int CELLS  = GRID_ROWS * GRID_COLS;
  localparam int CELL_W = $clog2(CELLS);
  localparam int SA_W   = $clog2(STACK_DEPTH);
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam logic [SP_W-1:0]   SP_FULL   = SP_W'(STACK_DEPTH);
  localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELLS - 1);

  state_e state_q, state_d;

  logic [COUNT_W-1:0]  thr_q, thr_d;
  logic [CELLS-1:0]    visited_q, visited_d;
  logic [SP_W-1:0]     sp_q, sp_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [COLOUR_W-1:0] target_q, target_d;
  logic [COORD_W-1:0]  pr_q, pr_d, pc_q, pc_d;
  logic [COORD_W-1:0]  nr_q, nr_d, nc_q, nc_d;
  logic [CELL_W-1:0]   nidx_q, nidx_d;
  dir_e                dir_q, dir_d;
  logic [CELL_W-1:0]   sweep_q, sweep_d;
  logic                out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]  match_count_q, match_count_d;
  logic                cleared_q, cleared_d;

  // memory ports
  logic                bd_we;
  logic [CELL_W-1:0]   bd_waddr, bd_raddr;
  logic [COLOUR_W-1:0] bd_wdata, bd_rdata;
  logic                st_we;
  logic [SA_W-1:0]     st_waddr, st_raddr;
  logic [ENTRY_W-1:0]  st_wdata, st_rdata;

  logic               in_acc, out_free, in_range;
  logic [CELL_W-1:0]  in_idx, cur_idx;
  logic               nb_ok;
  logic [COORD_W-1:0] nb_r, nb_c;
  logic [CELL_W-1:0]  nb_idx;
  logic               push_ok;

  gffmc_board_mem #(
    .CELLS  (CELLS),
    .CELL_W (CELL_W)
  ) u_board (
    .clk_i   (clk_i),
    .we_i    (bd_we),
    .waddr_i (bd_waddr),
    .wdata_i (bd_wdata),
    .raddr_i (bd_raddr),
    .rdata_o (bd_rdata)
  );

  gffmc_stack_mem #(
    .STACK_DEPTH (STACK_DEPTH),
    .SA_W        (SA_W)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_range   = (int'(row_i) < GRID_ROWS) && (int'(column_i) < GRID_COLS);
  assign in_idx     = CELL_W'(int'(row_i) * GRID_COLS + int'(column_i));
  assign cur_idx    = CELL_W'(int'(pr_q) * GRID_COLS + int'(pc_q));

  // neighbor probe: coordinates and bounds for the current direction
  always_comb begin
    nb_r  = pr_q;
    nb_c  = pc_q;
    nb_ok = 1'b0;
    unique case (dir_q)
      DIR_LEFT: begin
        nb_c  = pc_q - 4'd1;
        nb_ok = (pc_q != '0);
      end
      DIR_RIGHT: begin
        nb_c  = pc_q + 4'd1;
        nb_ok = (int'(pc_q) + 1 < GRID_COLS);
      end
      DIR_UP: begin
        nb_r  = pr_q - 4'd1;
        nb_ok = (pr_q != '0);
      end
      DIR_DOWN: begin
        nb_r  = pr_q + 4'd1;
        nb_ok = (int'(pr_q) + 1 < GRID_ROWS);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  assign nb_idx  = CELL_W'(int'(nb_r) * GRID_COLS + int'(nb_c));
  assign push_ok = (bd_rdata == target_q) && !visited_q[nidx_q] && (sp_q < SP_FULL);

  always_comb begin
    state_d       = state_q;
    thr_d         = cfg_we_i ? cfg_wdata_i : thr_q;
    visited_d     = visited_q;
    sp_d          = sp_q;
    count_d       = count_q;
    target_d      = target_q;
    pr_d          = pr_q;
    pc_d          = pc_q;
    nr_d          = nr_q;
    nc_d          = nc_q;
    nidx_d        = nidx_q;
    dir_d         = dir_q;
    sweep_d       = sweep_q;
    out_valid_d   = out_valid_q && out_stall_i;
    match_count_d = match_count_q;
    cleared_d     = cleared_q;

    bd_we    = 1'b0;
    bd_waddr = in_idx;
    bd_wdata = colour_i;
    bd_raddr = (state_q == S_IDLE) ? in_idx : nb_idx;
    st_we    = 1'b0;
    st_waddr = sp_q[SA_W-1:0];
    st_wdata = {nr_q, nc_q};
    st_raddr = SA_W'(sp_q - 1'b1);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_range && (op_e'(opcode_i) == OP_SELECT)) begin
            visited_d = '0;
            sp_d      = '0;
            count_d   = '0;
            pr_d      = COORD_W'(row_i);
            pc_d      = COORD_W'(column_i);
            state_d   = S_TARGET;
          end else begin
            bd_we         = in_range;
            out_valid_d   = 1'b1;
            match_count_d = '0;
            cleared_d     = 1'b0;
          end
        end
      end
      S_TARGET: begin
        // start cell always matches itself and fits
        target_d           = bd_rdata;
        st_we              = 1'b1;
        st_wdata           = {pr_q, pc_q};
        visited_d[cur_idx] = 1'b1;
        sp_d               = sp_q + 1'b1;
        state_d            = S_POP;
      end
      S_POP: begin
        if (sp_q == '0) begin
          if (count_q >= thr_q) begin
            sweep_d = '0;
            state_d = S_SWEEP;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          sp_d    = sp_q - 1'b1;
          state_d = S_POPWAIT;
        end
      end
      S_POPWAIT: begin
        pr_d    = st_rdata[ENTRY_W-1:COORD_W];
        pc_d    = st_rdata[COORD_W-1:0];
        count_d = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
        dir_d   = DIR_LEFT;
        state_d = S_NREAD;
      end
      S_NREAD: begin
        nr_d   = nb_r;
        nc_d   = nb_c;
        nidx_d = nb_idx;
        if (nb_ok && !visited_q[nb_idx]) begin
          state_d = S_NCHK;
        end else if (dir_q == DIR_DOWN) begin
          state_d = S_POP;
        end else begin
          dir_d = dir_e'(dir_q + 1'b1);
        end
      end
      S_NCHK: begin
        if (push_ok) begin
          st_we             = 1'b1;
          visited_d[nidx_q] = 1'b1;
          sp_d              = sp_q + 1'b1;
        end
        if (dir_q == DIR_DOWN) begin
          state_d = S_POP;
        end else begin
          dir_d   = dir_e'(dir_q + 1'b1);
          state_d = S_NREAD;
        end
      end
      S_SWEEP: begin
        bd_we    = visited_q[sweep_q];
        bd_waddr = sweep_q;
        bd_wdata = '0;
        sweep_d  = sweep_q + 1'b1;
        if (sweep_q == CELL_LAST) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          match_count_d = count_q;
          cleared_d     = (count_q >= thr_q);
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RESET;
      visited_q   <= '0;
      sp_q        <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      thr_q       <= thr_d;
      visited_q   <= visited_d;
      sp_q        <= sp_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q      <= target_d;
    pr_q          <= pr_d;
    pc_q          <= pc_d;
    nr_q          <= nr_d;
    nc_q          <= nc_d;
    nidx_q        <= nidx_d;
    dir_q         <= dir_d;
    sweep_q       <= sweep_d;
    match_count_q <= match_count_d;
    cleared_q     <= cleared_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = match_count_q;
  assign cleared_o     = cleared_q;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_FULL)
    else $error("stack pointer beyond stack depth");

  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> count_q != '0)
    else $error("select finished with zero count");

  a_start_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |-> visited_q != '0)
    else $error("fill running with empty visited map");

  a_cleared_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cleared_o |-> match_count_o != '0)
    else $error("cleared result with zero count");
`endif

endmodule

[bench/flood_match_checker.sv]
// Checker for the flood-fill block: predicts each item's match result and compares it.
module flood_match_checker
  import gffmc_pkg::*;
#(
  parameter int GRID_ROWS   = GRID_ROWS_DEF,
  parameter int GRID_COLS   = GRID_COLS_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               opcode_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         column_i,
  input  logic [2:0]         colour_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [COUNT_W-1:0] match_count_i,
  input  logic               cleared_i,
  output int                 pending_o,
  output int                 mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = GRID_ROWS * GRID_COLS;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               cleared;
  } match_t;

  logic [COLOUR_W-1:0] board_m   [CELLS];
  logic                visited_m [CELLS];
  logic [ENTRY_W-1:0]  stack_m   [STACK_DEPTH];
  int unsigned         stack_top;
  logic [COUNT_W-1:0]  threshold_m;
  match_t              expected_matches [$];
  match_t              want;
  int                  mismatches = 0;

  // Cell is marked when pushed, so it enters the stack at most once.
  function automatic void push_cell(int r, int c, logic [COLOUR_W-1:0] target);
    int idx;
    if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS) return;
    idx = r * GRID_COLS + c;
    if (board_m[idx] != target || visited_m[idx]) return;
    if (stack_top >= STACK_DEPTH) return;
    visited_m[idx]     = 1'b1;
    stack_m[stack_top] = {COORD_W'(r), COORD_W'(c)};
    stack_top++;
  endfunction

  function automatic match_t fill_and_clear(op_e op, logic [2:0] row, logic [2:0] col,
                                            logic [2:0] colour);
    match_t              res;
    logic [COLOUR_W-1:0] target;
    logic [ENTRY_W-1:0]  entry;
    int                  r;
    int                  c;
    int unsigned         count;
    res = '0;
    if (int'(row) >= GRID_ROWS || int'(col) >= GRID_COLS) return res;
    if (op == OP_WRITE) begin
      board_m[int'(row) * GRID_COLS + int'(col)] = colour;
      return res;
    end
    target = board_m[int'(row) * GRID_COLS + int'(col)];
    foreach (visited_m[i]) visited_m[i] = 1'b0;
    stack_top = 0;
    count     = 0;
    push_cell(int'(row), int'(col), target);
    while (stack_top > 0) begin
      stack_top--;
      entry = stack_m[stack_top];
      r     = int'(entry[ENTRY_W-1:COORD_W]);
      c     = int'(entry[COORD_W-1:0]);
      if (count < COUNT_MAX) count++;
      push_cell(r, c - 1, target);
      push_cell(r, c + 1, target);
      push_cell(r - 1, c, target);
      push_cell(r + 1, c, target);
    end
    res.count = COUNT_W'(count);
    if (count >= threshold_m) begin
      res.cleared = 1'b1;
      foreach (visited_m[i]) if (visited_m[i]) board_m[i] = '0;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      threshold_m = THR_RESET;
      expected_matches.delete();
    end else begin
      if (cfg_we_i) threshold_m = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_matches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transaction with none pending: count %0d cleared %0b",
                     $time, match_count_i, cleared_i);
        end else begin
          want = expected_matches.pop_front();
          if (want.count !== match_count_i || want.cleared !== cleared_i) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected count %0d cleared %0b, got count %0d cleared %0b",
                       $time, want.count, want.cleared, match_count_i, cleared_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_matches.push_back(fill_and_clear(op_e'(opcode_i), row_i, column_i, colour_i));
    end
    pending_o        <= expected_matches.size();
    mismatch_count_o <= mismatches;
  end

endmodule

[bench/testbench.sv]
// Testbench top: clock, reset, stimulus, receiver stalls, watchdog and verdict.
module testbench import gffmc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 155;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int THR_PLAN     [PHASES] = '{1, 25, 0, 31, 3, 2, 0, 12};
  localparam int TX_IDLE_PLAN [PHASES] = '{0, 76, 0, 24, 76, 0, 24, 0};
  localparam int RX_STALL_PLAN[PHASES] = '{0, 0, 76, 24, 0, 76, 24, 0};
  localparam int PALETTE_PLAN [PHASES] = '{2, 1, 2, 3, 2, 1, 2, 3};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               opcode    = 1'b0;
  logic [2:0]         row       = '0;
  logic [2:0]         column    = '0;
  logic [2:0]         colour    = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [COUNT_W-1:0] match_count;
  logic               cleared;
  int                 pending;
  int                 mismatch_count;
  int                 tx_idle_pct  = 0;
  int                 rx_stall_pct = 0;

  grid_flood_fill_match_clear i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .row_i        (row),
    .column_i     (column),
    .colour_i     (colour),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .match_count_o(match_count),
    .cleared_o    (cleared)
  );

  flood_match_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .row_i           (row),
    .column_i        (column),
    .colour_i        (colour),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .match_count_i   (match_count),
    .cleared_i       (cleared),
    .pending_o       (pending),
    .mismatch_count_o(mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Counts cycles without any accepted transaction on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_MAX) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Presents one item, holds it until accepted, then maybe leaves a gap.
  task automatic send_item(input op_e op, input logic [2:0] r, input logic [2:0] c,
                           input logic [2:0] colour_v);
    in_valid <= 1'b1;
    opcode   <= op;
    row      <= r;
    column   <= c;
    colour   <= colour_v;
    do @(posedge clk); while (in_stall);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [COUNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int         pick;
    logic [2:0] r;
    logic [2:0] c;
    logic [2:0] col;
    op_e        op;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every cell is written before any select: rows 0-1 one colour, row 2 empty,
    // rows 3-4 a checkerboard of two colours.
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        send_item(OP_WRITE, 3'(i), 3'(j),
                  (i < 2) ? 3'd1 : (i == 2) ? 3'd0 : 3'(2 + ((i + j) & 1)));

    // Directed part under the reset threshold.
    send_item(OP_SELECT, 3'd0, 3'd0, 3'd0);   // ten cells, cleared
    send_item(OP_SELECT, 3'd2, 3'd4, 3'd7);   // empty region fills like a colour
    send_item(OP_WRITE,  3'd7, 3'd0, 3'd5);   // off-grid writes are dropped
    send_item(OP_WRITE,  3'd0, 3'd7, 3'd4);
    send_item(OP_SELECT, 3'd5, 3'd0, 3'd0);   // off-grid selects
    send_item(OP_SELECT, 3'd0, 3'd6, 3'd0);
    send_item(OP_SELECT, 3'd7, 3'd7, 3'd7);
    send_item(OP_WRITE,  3'd0, 3'd0, 3'd6);   // colours six and seven
    send_item(OP_WRITE,  3'd4, 3'd4, 3'd7);
    send_item(OP_SELECT, 3'd0, 3'd0, 3'd0);
    send_item(OP_SELECT, 3'd4, 3'd4, 3'd0);
    send_item(OP_WRITE,  3'd0, 3'd1, 3'd6);
    send_item(OP_WRITE,  3'd1, 3'd0, 3'd6);
    send_item(OP_SELECT, 3'd1, 3'd0, 3'd0);   // count equals threshold
    send_item(OP_SELECT, 3'd3, 3'd0, 3'd0);
    send_item(OP_WRITE,  3'd4, 3'd0, 3'd5);
    send_item(OP_WRITE,  3'd0, 3'd4, 3'd4);
    send_item(OP_SELECT, 3'd0, 3'd4, 3'd0);
    send_item(OP_WRITE,  3'd2, 3'd2, 3'd3);
    send_item(OP_SELECT, 3'd2, 3'd2, 3'd0);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      write_threshold((p == 6) ? COUNT_W'($urandom_range(25, 1)) : COUNT_W'(THR_PLAN[p]));
      tx_idle_pct  = TX_IDLE_PLAN[p];
      rx_stall_pct = RX_STALL_PLAN[p];
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        r    = 3'($urandom_range(4));
        c    = 3'($urandom_range(4));
        col  = 3'($urandom_range(7));
        if (pick < 10) begin
          op = op_e'($urandom_range(1));
          if ($urandom_range(1)) r = 3'($urandom_range(7, 5));
          else c = 3'($urandom_range(7, 5));
        end else if (pick < 55) begin
          op = OP_WRITE;
          // a small palette keeps regions large enough to reach high thresholds
          if ($urandom_range(9) != 0) col = 3'($urandom_range(PALETTE_PLAN[p]));
        end else begin
          op = OP_SELECT;
        end
        send_item(op, r, c, col);
      end
      drain_results();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
    end

    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
rtl/gffmc_pkg.sv
rtl/gffmc_board_mem.sv
rtl/gffmc_stack_mem.sv
rtl/grid_flood_fill_match_clear.sv
bench/flood_match_checker.sv
bench/testbench.sv
